// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; take in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/bsc_pkg.sv =====
// Types, constants and the CRC byte function of the byte stream checksum.
// Depends on nothing.
package bsc_pkg;

   localparam logic [1:0]  MODE_BSD  = 2'd0;
   localparam logic [1:0]  MODE_SYSV = 2'd1;
   localparam logic [1:0]  MODE_CRC  = 2'd2;

   localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
   localparam logic [16:0] SYSV_MOD  = 17'h0_FFFF;

   localparam int          QUEUE_DEPTH = 2;
   localparam int          QPTR_BITS   = 1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [31:0] checksum;
      logic [39:0] byte_total;
      logic        count_overflow;
   } rsp_item_type;

   // Entry of the queue between front and back
   typedef struct packed {
      logic       is_end;
      logic [7:0] data;
   } queue_entry_type;

   typedef enum logic {
      BACK_RUN,
      BACK_LEN
   } back_state_type;

   // One byte of CRC-32, MSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'd0};
      for (int k = 0; k < 8; k++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/bsc_front.sv =====
// Front end: accepts request transfers, classifies them and buffers them in a
// two-entry queue for the back end. Depends on bsc_pkg.
module bsc_front
   import bsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_item_type    req_data,
   output logic            q_valid,
   output queue_entry_type q_entry,
   input  logic            q_pop
);

   queue_entry_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]           fill_ff, fill_in;
   logic                         push;
   queue_entry_type              entry;

   // Classify the incoming transfer
   always_comb begin
      entry.is_end = req_data.req_type;
      entry.data   = req_data.data_byte;
   end

   assign req_ready = (fill_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != '0);
   assign q_entry   = mem_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the transfer
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== rtl/bsc_back.sv =====
// Back end: runs the three accumulators, feeds the length bytes into the CRC
// and holds the result in an output register. Depends on bsc_pkg.
module bsc_back
   import bsc_pkg::*;
#(
   parameter int COUNT_BITS = 40
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [1:0]      mode,
   input  logic            q_valid,
   input  queue_entry_type q_entry,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_item_type    rsp_data
);

   back_state_type          state_ff, state_in;
   logic [15:0]             rot_ff, rot_in;
   logic [15:0]             sysv_ff, sysv_in;
   logic [31:0]             crc_ff, crc_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                    sat_ff, sat_in;
   logic [COUNT_BITS-1:0]   len_ff, len_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_ff, rsp_in;
   logic                    out_free;
   logic                    load;
   logic [31:0]             sum;
   logic [16:0]             sysv_add;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign sysv_add  = {1'b0, sysv_ff} + {9'd0, q_entry.data};

   // Next state, accumulators and result
   always_comb begin
      state_in     = state_ff;
      rot_in       = rot_ff;
      sysv_in      = sysv_ff;
      crc_in       = crc_ff;
      cnt_in       = cnt_ff;
      sat_in       = sat_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      load         = 1'b0;
      sum          = '0;

      unique case (state_ff)
         BACK_RUN: begin
            if (q_valid) begin
               if (!q_entry.is_end) begin
                  q_pop  = 1'b1;
                  rot_in = {rot_ff[0], rot_ff[15:1]} + {8'd0, q_entry.data};
                  sysv_in = (sysv_add >= SYSV_MOD) ? 16'(sysv_add - SYSV_MOD)
                                                   : sysv_add[15:0];
                  crc_in = crc_byte(crc_ff, q_entry.data);
                  if (&cnt_ff) begin
                     sat_in = 1'b1;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else if (mode == MODE_CRC && cnt_ff != '0) begin
                  // Length bytes follow, low byte first
                  q_pop    = 1'b1;
                  len_in   = cnt_ff;
                  state_in = BACK_LEN;
               end else if (out_free) begin
                  q_pop = 1'b1;
                  load  = 1'b1;
                  unique case (mode)
                     MODE_BSD:  sum = {16'd0, rot_ff};
                     MODE_SYSV: sum = {16'd0, sysv_ff};
                     MODE_CRC:  sum = ~crc_ff;
                     default:   sum = '0;
                  endcase
               end
            end
         end
         BACK_LEN: begin
            if (len_ff != '0) begin
               crc_in = crc_byte(crc_ff, len_ff[7:0]);
               len_in = len_ff >> 8;
            end else if (out_free) begin
               load     = 1'b1;
               sum      = ~crc_ff;
               state_in = BACK_RUN;
            end
         end
         default: state_in = BACK_RUN;
      endcase

      // Emit the result and drop the stream state
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.checksum       = sum;
         rsp_in.byte_total     = 40'(cnt_ff);
         rsp_in.count_overflow = sat_ff;
         rot_in                = '0;
         sysv_in               = '0;
         crc_in                = '0;
         cnt_in                = '0;
         sat_in                = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_RUN;
         rot_ff       <= '0;
         sysv_ff      <= '0;
         crc_ff       <= '0;
         cnt_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         sysv_ff      <= sysv_in;
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== rtl/byte_stream_checksum_top.sv =====
// Byte stream checksum: BSD rotate sum, SysV sum or POSIX CRC-32 cksum.
// One data byte per cycle while nothing holds the back end: an end transfer holds it, longer
// in CRC mode with a nonzero count, and so does any stall on the result side. The result
// of an end transfer is registered in the back end; in CRC mode with a nonzero count it first
// feeds the n significant count bytes (1 to COUNT_BITS/8 rounded up) into the CRC, one
// length byte per cycle. Reset is synchronous, active high: mode returns to BSD, the queue
// empties and all accumulators clear at once.
module byte_stream_checksum_top
   import bsc_pkg::*;
#(
   parameter int COUNT_BITS = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_write_en,
   input  logic [1:0]   csr_write_data
);

   logic [1:0]      mode_reg_ff;
   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   // Hold the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_reg_ff <= MODE_BSD;
      end else if (csr_write_en) begin
         mode_reg_ff <= csr_write_data;
      end
   end

   bsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop)
   );

   bsc_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_reg_ff),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/bsc_checker.sv =====
// Port-level checks on the byte stream checksum top level, bound to it below.
// Depends on bsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsc_checker
   import bsc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   // A stalled result holds
   `ASSERT_NEXT(rsp_hold_chk, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Reset drops any pending result
   `ASSERT_NEXT(rsp_reset_chk, clock, 1'b0, reset, !rsp_valid)

   // Queue is empty after reset, so the request side is open
   `ASSERT_NEXT(req_reset_chk, clock, 1'b0, reset, req_ready)

   // A saturated count reports all ones in its low bits
   `ASSERT_IMPLY(sat_chk, clock, reset, rsp_valid && rsp_data.count_overflow, rsp_data.byte_total[15:0] == 16'hFFFF)

endmodule

bind byte_stream_checksum_top bsc_checker u_bsc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/byte_stream_checksum_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for byte_stream_checksum_top: byte streams in every mode, checked field by field
// against a scoreboard that keeps its own BSD, SysV and CRC-32 accumulators.
// Depends on bsc_pkg and the byte_stream_checksum_top RTL.
module byte_stream_checksum_top_tb;
   import bsc_pkg::*;

   // A narrow count keeps the CRC length tail to at most two bytes
   localparam int         COUNT_BITS     = 16;
   localparam int         CLOCK_PERIOD   = 10;
   localparam int         RESET_CYCLES   = 4;
   localparam int         ITEM_TARGET    = 1000;
   localparam int         IDLE_PERCENT   = 23;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         DRAIN_CYCLES   = 3 + COUNT_BITS / 8 + 4;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam logic       REQ_BYTE       = 1'b0;
   localparam logic       REQ_END        = 1'b1;

   typedef enum {
      FILL_ONES,
      FILL_ZEROS,
      FILL_RANDOM
   } fill_kind_type;

   // Running sums of the current stream and the results they lead to
   class checksum_scoreboard;
      logic [1:0]            mode;
      logic [15:0]           rotate_sum;
      logic [15:0]           byte_sum;
      logic [31:0]           crc_reg;
      logic [COUNT_BITS-1:0] byte_count;
      logic                  saturated;
      rsp_item_type          expected_q[$];
      int                    failures;
      int                    results_seen;

      function new();
         mode         = MODE_BSD;
         failures     = 0;
         results_seen = 0;
         clear_sums();
      endfunction

      function void clear_sums();
         rotate_sum = '0;
         byte_sum   = '0;
         crc_reg    = '0;
         byte_count = '0;
         saturated  = 1'b0;
      endfunction

      // Shift one byte through the CRC register bit by bit, MSB first
      function logic [31:0] crc_shift(logic [31:0] crc, logic [7:0] b);
         logic [31:0] c;
         logic        feedback;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            feedback = c[31] ^ b[i];
            c = {c[30:0], 1'b0} ^ (feedback ? CRC_POLY : 32'd0);
         end
         return c;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_input(req_item_type item);
         logic [16:0]           wide_sum;
         logic [31:0]           crc_tail;
         logic [COUNT_BITS-1:0] len;
         rsp_item_type          expected;
         if (item.req_type == REQ_BYTE) begin
            // Advance every accumulator, whatever the mode
            rotate_sum = {rotate_sum[0], rotate_sum[15:1]} + 16'(item.data_byte);
            wide_sum   = {1'b0, byte_sum} + 17'(item.data_byte);
            if (wide_sum >= SYSV_MOD) begin
               wide_sum = wide_sum - SYSV_MOD;
            end
            byte_sum = wide_sum[15:0];
            crc_reg  = crc_shift(crc_reg, item.data_byte);
            if (&byte_count) begin
               saturated = 1'b1;
            end else begin
               byte_count = byte_count + 1'b1;
            end
         end else begin
            case (mode)
               MODE_BSD: begin
                  expected.checksum = {16'd0, rotate_sum};
               end
               MODE_SYSV: begin
                  expected.checksum = {16'd0, byte_sum};
               end
               MODE_CRC: begin
                  // Append the significant count bytes, low byte first, then invert
                  crc_tail = crc_reg;
                  len      = byte_count;
                  while (len != 0) begin
                     crc_tail = crc_shift(crc_tail, len[7:0]);
                     len      = len >> 8;
                  end
                  expected.checksum = ~crc_tail;
               end
               default: begin
                  expected.checksum = 32'd0;
               end
            endcase
            expected.byte_total     = 40'(byte_count);
            expected.count_overflow = saturated;
            expected_q.push_back(expected);
            clear_sums();
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t: result with none expected: checksum %h total %0d overflow %b",
                     $time, got.checksum, got.byte_total, got.count_overflow);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (got.checksum !== want.checksum) begin
            $display("%0t: checksum expected %h actual %h", $time, want.checksum, got.checksum);
            failures++;
         end
         if (got.byte_total !== want.byte_total) begin
            $display("%0t: byte_total expected %0d actual %0d",
                     $time, want.byte_total, got.byte_total);
            failures++;
         end
         if (got.count_overflow !== want.count_overflow) begin
            $display("%0t: count_overflow expected %b actual %b",
                     $time, want.count_overflow, got.count_overflow);
            failures++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic         csr_write_en;
   logic [1:0]   csr_write_data;

   logic               steady;
   logic               hold_request;
   bit                 hold_taken   = 1'b0;
   int                 hold_left    = 0;
   int                 items_sent   = 0;
   int                 quiet_cycles = 0;
   checksum_scoreboard sums;

   byte_stream_checksum_top #(
      .COUNT_BITS(COUNT_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Offer one item, idling first at random, and hold it until the transfer
   task automatic send_item(input req_item_type item);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sums.note_input(item);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_item_type item;
      item.req_type  = REQ_BYTE;
      item.data_byte = b;
      send_item(item);
   endtask

   // The data byte of an end item is ignored, so fill it with noise
   task automatic send_end();
      req_item_type item;
      item.req_type  = REQ_END;
      item.data_byte = 8'($urandom);
      send_item(item);
   endtask

   task automatic send_stream(input int length, input fill_kind_type fill);
      logic [7:0] b;
      for (int i = 0; i < length; i++) begin
         case (fill)
            FILL_ONES:  b = 8'hFF;
            FILL_ZEROS: b = 8'h00;
            default:    b = 8'($urandom);
         endcase
         send_byte(b);
      end
      send_end();
   endtask

   // Mostly short streams; a few long enough to wrap the sums and use two count bytes
   task automatic send_random_stream();
      int            pick;
      int            length;
      fill_kind_type fill;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         length = 0;
      end else if (pick < 85) begin
         length = $urandom_range(1, 24);
      end else if (pick < 96) begin
         length = $urandom_range(25, 120);
      end else begin
         length = $urandom_range(250, 600);
      end
      pick = $urandom_range(0, 5);
      fill = (pick == 0) ? FILL_ONES : (pick == 1) ? FILL_ZEROS : FILL_RANDOM;
      send_stream(length, fill);
   endtask

   // Write the mode only once the block has drained
   task automatic set_mode(input logic [1:0] next_mode);
      req_valid <= 1'b0;
      while (sums.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= next_mode;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sums.mode = next_mode;
   endtask

   // Take results, idle at random, and hold off once for a long stretch on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sums.check_result(rsp_data);
      end
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // End the run if nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [1:0] mode_pool [3];
      int         phase;
      int         streams;
      mode_pool = '{MODE_BSD, MODE_SYSV, MODE_CRC};
      sums      = new();

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data       <= '0;
      rsp_ready      <= 1'b0;
      csr_write_en   <= 1'b0;
      csr_write_data <= MODE_BSD;
      steady         <= 1'b0;
      hold_request   <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // BSD after reset: byte extremes, a carry round the rotate, then an empty stream
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'h80);
      send_end();
      send_end();

      // SysV: top bytes, then an empty stream
      set_mode(MODE_SYSV);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_end();
      send_end();

      // CRC: zero and top byte; the empty stream gives all ones
      set_mode(MODE_CRC);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_end();
      send_end();

      // Unused mode reports a zero checksum but the usual count
      set_mode(MODE_UNUSED);
      send_byte(8'h55);
      send_end();

      // Random phases, each under a freshly written mode
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            set_mode(MODE_UNUSED);
         end else begin
            set_mode(mode_pool[$urandom_range(0, 2)]);
         end
         steady <= (phase == 3);
         if (phase == 1) begin
            // Back up the result side so the block fills and stalls its input
            hold_request <= 1'b1;
            repeat (16) send_stream($urandom_range(0, 8), FILL_RANDOM);
         end else begin
            streams = (phase == 3) ? 10 : $urandom_range(1, 6);
            repeat (streams) send_random_stream();
         end
         phase++;
      end

      // Drain and report
      req_valid <= 1'b0;
      while (sums.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sums.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
